>>> rtl/core/tma_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triangular moving average block.
// No dependencies; compiled before every other file of the block.
package tma_pkg;

   localparam int DEFAULT_MAX_WINDOW  = 64;
   localparam int DEFAULT_SAMPLE_BITS = 24;
   localparam int WINDOW_REG_BITS     = 7;
   localparam logic [WINDOW_REG_BITS-1:0] WINDOW_RESET = 7'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

>>> rtl/core/tma_req_if.sv
`timescale 1ns / 1ps
// Request channel of the triangular moving average: one sample per request.
// Depends on tma_pkg for the default sample width.
interface tma_req_if #(
   parameter int SAMPLE_BITS = tma_pkg::DEFAULT_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          series_end;

   modport source (output valid, output sample, output series_end, input ready);
   modport sink   (input valid, input sample, input series_end, output ready);
endinterface

>>> rtl/core/tma_rsp_if.sv
`timescale 1ns / 1ps
// Response channel of the triangular moving average: one average per response.
// Depends on tma_pkg for the default sample width.
interface tma_rsp_if #(
   parameter int SAMPLE_BITS = tma_pkg::DEFAULT_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

>>> rtl/core/triangular_moving_average.sv
`timescale 1ns / 1ps
// Triangular moving average: delay line RAM, sequenced weighted sum, rounding divider.
// Depends on tma_pkg, tma_req_if, tma_rsp_if and tma_ram.
//
//   channel   direction  payload                           handshake
//   req_if    in         sample (signed), series_end       valid/ready
//   rsp_if    out        average (signed)                  valid/ready
//   csr_*     in         csr_wdata = window length (7 b)   csr_we, no wait
//
// A request that yields no average (warm-up) leaves the sequencer in idle. One
// that yields an average runs p delay-line reads (p = window length) through the
// multiply-accumulate pipe, then one quotient bit per cycle in the restoring
// divider over ACC_BITS = SAMPLE_BITS + TOTAL_BITS bits, 35 at the defaults.
// Reset (synchronous, active high) clears the counts and pointer, returns the
// window register to 9 and the sequencer to idle; the delay line is not cleared,
// only entries of the current series are read.
// req_if.ready is high only in idle; the finished average waits in the output
// register, and a following request may be taken while it waits.
module triangular_moving_average #(
   parameter int MAX_WINDOW  = tma_pkg::DEFAULT_MAX_WINDOW,
   parameter int SAMPLE_BITS = tma_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tma_req_if.sink                               req_if,
   tma_rsp_if.source                             rsp_if,
   input  logic                                  csr_we,
   input  logic [tma_pkg::WINDOW_REG_BITS-1:0]   csr_wdata
);
   // widths
   localparam int PTR_BITS    = $clog2(MAX_WINDOW);
   localparam int P_BITS      = $clog2(MAX_WINDOW + 1);       // window and seen count
   localparam int K_BITS      = P_BITS + 1;                   // tap counter, holds p+1
   localparam int WEIGHT_BITS = $clog2((MAX_WINDOW + 1) / 2 + 1);
   localparam int TOTAL_MAX   = (MAX_WINDOW / 2 + 1) * (MAX_WINDOW / 2 + 1);
   localparam int TOTAL_BITS  = $clog2(TOTAL_MAX + 1);
   localparam int PROD_BITS   = SAMPLE_BITS + WEIGHT_BITS + 1;
   localparam int ACC_BITS    = SAMPLE_BITS + TOTAL_BITS;
   localparam int CNT_BITS    = $clog2(ACC_BITS);
   localparam int WIN_BITS    = tma_pkg::WINDOW_REG_BITS;

   tma_pkg::state_type state_ff, state_in;

   logic [WIN_BITS-1:0]          window_ff, window_in;
   logic [P_BITS-1:0]            seen_ff, seen_in;
   logic [PTR_BITS-1:0]          wp_ff, wp_in;
   logic [P_BITS-1:0]            p_ff, p_in;
   logic [PTR_BITS-1:0]          pos_ff, pos_in;
   logic [K_BITS-1:0]            k_ff, k_in;
   logic [WEIGHT_BITS-1:0]       w1_ff, w1_in;
   logic                         v1_ff, v1_in;
   logic                         v2_ff, v2_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [TOTAL_BITS-1:0]        total_ff, total_in;
   logic [ACC_BITS-1:0]          quo_ff, quo_in;
   logic [TOTAL_BITS-1:0]        rem_ff, rem_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                         neg_ff, neg_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]       rsp_avg_ff, rsp_avg_in;

   // combinational helpers
   logic                         accept;
   logic [P_BITS-1:0]            p_eff;
   logic [PTR_BITS-1:0]          wp_next;
   logic [P_BITS-1:0]            seen_next;
   logic [PTR_BITS+1:0]          start_raw;
   logic [PTR_BITS-1:0]          pos_start;
   logic [P_BITS-1:0]            half;
   logic [P_BITS-1:0]            half_p1;
   logic [2*P_BITS-1:0]          total_full;
   logic [K_BITS-1:0]            mirror;
   logic [K_BITS-1:0]            weight_k;
   logic                         issue;
   logic [ACC_BITS-1:0]          mag;
   logic [TOTAL_BITS:0]          shifted;
   logic                         fits;
   logic [SAMPLE_BITS-1:0]       qmag;

   logic                         ram_wr_en;
   logic [SAMPLE_BITS-1:0]       ram_rd_data;

   assign accept = req_if.valid && req_if.ready;

   // out-of-range window: 0 acts as 1, above MAX_WINDOW acts as MAX_WINDOW
   always_comb begin
      if (window_ff == '0) begin
         p_eff = P_BITS'(1);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         p_eff = P_BITS'(MAX_WINDOW);
      end else begin
         p_eff = P_BITS'(window_ff);
      end
   end

   assign wp_next   = (32'(wp_ff) == MAX_WINDOW - 1) ? '0 : wp_ff + 1'b1;
   assign seen_next = (32'(seen_ff) == MAX_WINDOW) ? seen_ff : seen_ff + 1'b1;

   // oldest sample of the window: wp_next - p, modulo MAX_WINDOW
   assign start_raw = {2'b00, wp_next} + (PTR_BITS+2)'(MAX_WINDOW) - (PTR_BITS+2)'(p_eff);
   assign pos_start = (32'(start_raw) >= MAX_WINDOW)
                      ? PTR_BITS'(start_raw - (PTR_BITS+2)'(MAX_WINDOW))
                      : PTR_BITS'(start_raw);

   // weight total: (p/2+1)^2 for odd p, (p/2+1)(p/2) for even p
   assign half       = p_eff >> 1;
   assign half_p1    = half + 1'b1;
   assign total_full = p_eff[0] ? (2*P_BITS)'(half_p1) * (2*P_BITS)'(half_p1)
                                : (2*P_BITS)'(half_p1) * (2*P_BITS)'(half);

   // tap weight min(k, p+1-k)
   assign mirror   = {1'b0, p_ff} + 1'b1 - k_ff;
   assign weight_k = (k_ff < mirror) ? k_ff : mirror;
   assign issue    = (state_ff == tma_pkg::ST_SUM) && (k_ff <= {1'b0, p_ff});

   assign mag     = acc_ff[ACC_BITS-1] ? ACC_BITS'(-acc_ff) : ACC_BITS'(acc_ff);
   assign shifted = {rem_ff, quo_ff[ACC_BITS-1]};
   assign fits    = shifted >= {1'b0, total_ff};
   assign qmag    = quo_ff[SAMPLE_BITS-1:0];

   assign ram_wr_en = accept;

   tma_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_if.sample),
      .rd_en   (issue),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      window_in    = csr_we ? csr_wdata : window_ff;
      seen_in      = seen_ff;
      wp_in        = wp_ff;
      p_in         = p_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      w1_in        = w1_ff;
      v1_in        = 1'b0;
      v2_in        = 1'b0;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      total_in     = total_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_avg_in   = rsp_avg_ff;

      unique case (state_ff)
         tma_pkg::ST_IDLE: begin
            if (accept) begin
               // series end clears counts now; the window start is already captured
               wp_in    = req_if.series_end ? '0 : wp_next;
               seen_in  = req_if.series_end ? '0 : seen_next;
               p_in     = p_eff;
               pos_in   = pos_start;
               k_in     = K_BITS'(1);
               acc_in   = '0;
               total_in = TOTAL_BITS'(total_full);
               if (seen_next >= p_eff) begin
                  state_in = tma_pkg::ST_SUM;
               end
            end
         end
         tma_pkg::ST_SUM: begin
            // read -> multiply -> accumulate, one tap per cycle
            if (issue) begin
               pos_in = (32'(pos_ff) == MAX_WINDOW - 1) ? '0 : pos_ff + 1'b1;
               k_in   = k_ff + 1'b1;
               w1_in  = WEIGHT_BITS'(weight_k);
            end
            v1_in = issue;
            v2_in = v1_ff;
            if (v1_ff) begin
               prod_in = $signed(ram_rd_data) * $signed({1'b0, w1_ff});
            end
            if (v2_ff) begin
               acc_in = acc_ff + ACC_BITS'(prod_ff);
            end
            if (!issue && !v1_ff && !v2_ff) begin
               state_in = tma_pkg::ST_PREP;
            end
         end
         tma_pkg::ST_PREP: begin
            // round half away from zero: divide |sum| + total/2
            neg_in   = acc_ff[ACC_BITS-1];
            quo_in   = mag + ACC_BITS'(total_ff >> 1);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = tma_pkg::ST_DIV;
         end
         tma_pkg::ST_DIV: begin
            rem_in = fits ? TOTAL_BITS'(shifted - {1'b0, total_ff}) : TOTAL_BITS'(shifted);
            quo_in = {quo_ff[ACC_BITS-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(ACC_BITS - 1)) begin
               state_in = tma_pkg::ST_DONE;
            end
         end
         tma_pkg::ST_DONE: begin
            if (!rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = neg_ff ? -qmag : qmag;
               state_in     = tma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tma_pkg::ST_IDLE;
         window_ff    <= tma_pkg::WINDOW_RESET;
         seen_ff      <= '0;
         wp_ff        <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         seen_ff      <= seen_in;
         wp_ff        <= wp_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      pos_ff     <= pos_in;
      k_ff       <= k_in;
      w1_ff      <= w1_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      total_ff   <= total_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   assign req_if.ready   = (state_ff == tma_pkg::ST_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.average = rsp_avg_ff;

`ifndef SYNTH
   // a new average is only loaded from the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == tma_pkg::ST_DONE)
      else $error("response raised outside done state");

   // divider remainder stays below the weight total
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == tma_pkg::ST_DIV |-> rem_ff < total_ff)
      else $error("divider remainder out of range");

   // seen count saturates and the write pointer wraps inside the delay line
   a_counts: assert property (@(posedge clock) disable iff (reset)
      32'(seen_ff) <= MAX_WINDOW && 32'(wp_ff) < MAX_WINDOW)
      else $error("seen count or write pointer out of range");

   // the multiply-accumulate pipe is empty whenever the sum phase is left
   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == tma_pkg::ST_PREP |-> !v1_ff && !v2_ff)
      else $error("sum pipeline not drained");
`endif
endmodule

>>> rtl/core/tma_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tma_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the triangular moving average block.
// Depends on tma_pkg, tma_req_if, tma_rsp_if and the triangular_moving_average RTL.
module tb_top;

   localparam int SAMPLE_BITS    = tma_pkg::DEFAULT_SAMPLE_BITS;
   localparam int MAX_WINDOW     = tma_pkg::DEFAULT_MAX_WINDOW;
   localparam int ITEMS_TARGET   = 1300;
   // worst average: MAX_WINDOW reads plus a 35-bit restoring divide, doubled
   localparam int SETTLE_CYCLES  = 2 * (MAX_WINDOW + 48);
   localparam int LONG_HOLD      = 600;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef logic signed [SAMPLE_BITS-1:0]          sample_type;
   typedef logic [tma_pkg::WINDOW_REG_BITS-1:0]    window_type;

   localparam sample_type SAMPLE_MAX = sample_type'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam sample_type SAMPLE_MIN = sample_type'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   // receive-side stall patterns
   typedef enum int {
      SINK_OPEN,
      SINK_LIGHT,
      SINK_HEAVY,
      SINK_PERIODIC
   } sink_mode_type;

   // ---------------------------------------------------------------------
   // Scoreboard: mirrors the delay line and window register, predicts the
   // rounded triangular average for every accepted request past the warm-up.
   // ---------------------------------------------------------------------
   class average_scoreboard;
      longint     delay_line[MAX_WINDOW];
      int         seen_count;
      int         write_ptr;
      window_type window_reg;
      sample_type expected_averages[$];
      int         errors;
      int         requests;
      int         series_done;
      int         averages;

      function new();
         seen_count = 0;
         write_ptr  = 0;
         window_reg = tma_pkg::WINDOW_RESET;
         errors     = 0;
         requests   = 0;
         series_done = 0;
         averages   = 0;
      endfunction

      // window as the block applies it: 0 acts as 1, clamps at MAX_WINDOW
      function int span();
         if (window_reg == 0) return 1;
         if (window_reg > MAX_WINDOW) return MAX_WINDOW;
         return int'(window_reg);
      endfunction

      function void set_window(window_type value);
         window_reg = value;
      endfunction

      function void take_sample(sample_type value, logic last);
         int     p;
         int     half;
         int     k;
         int     idx;
         int     weight;
         longint total;
         longint acc;
         longint mag;
         longint quot;
         requests++;
         delay_line[write_ptr] = longint'(value);
         write_ptr = (write_ptr + 1) % MAX_WINDOW;
         if (seen_count < MAX_WINDOW) seen_count++;
         p = span();
         if (seen_count >= p) begin
            half  = p / 2;
            total = (p % 2 == 1) ? longint'((half + 1) * (half + 1))
                                 : longint'((half + 1) * half);
            idx = (write_ptr + MAX_WINDOW - p) % MAX_WINDOW;
            acc = 0;
            for (k = 1; k <= p; k++) begin
               weight = (k < p + 1 - k) ? k : p + 1 - k;
               acc += delay_line[idx] * longint'(weight);
               idx = (idx + 1) % MAX_WINDOW;
            end
            // round half away from zero on the magnitude
            mag  = (acc < 0) ? -acc : acc;
            quot = (mag + total / 2) / total;
            if (acc < 0) quot = -quot;
            expected_averages.push_back(sample_type'(quot));
         end
         if (last) begin
            seen_count = 0;
            write_ptr  = 0;
            series_done++;
         end
      endfunction

      function void match_average(sample_type got);
         sample_type want;
         if (expected_averages.size() == 0) begin
            errors++;
            $display("%0t: unexpected average, expected none, actual %0d", $time, got);
            return;
         end
         want = expected_averages.pop_front();
         averages++;
         if (got !== want) begin
            errors++;
            $display("%0t: average mismatch, expected %0d, actual %0d", $time, want, got);
         end
      endfunction

      function void close_out();
         if (expected_averages.size() != 0) begin
            errors++;
            $display("%0t: %0d averages never arrived, next expected %0d", $time,
                     expected_averages.size(), expected_averages[0]);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset, channels and the block
   // ---------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   window_type csr_wdata;

   always #2 clock = ~clock;

   tma_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   tma_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_ch ();

   triangular_moving_average #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   average_scoreboard sb = new();

   int burst_left    = 0;    // requests left in the current sender burst
   int windows_tried = 0;
   bit long_hold_req = 1'b0; // asks the receiver for one long hold-off

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one request and block until it is taken. Gaps come only between
   // bursts, so valid never drops and rises in the same step.
   task automatic send_sample(input sample_type value, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid      <= 1'b1;
      req_ch.sample     <= value;
      req_ch.series_end <= last;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_sample(value, last);
   endtask

   // Stop sending, let every outstanding average drain, give the block
   // time to finish any warm-up request, then write the window register.
   task automatic write_window(input window_type value);
      req_ch.valid <= 1'b0;
      while (sb.expected_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_window(value);
      windows_tried++;
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return sample_type'(int'($urandom_range(0, 32)) - 16);
         3:       return SAMPLE_MAX - sample_type'($urandom_range(0, 255));
         4:       return SAMPLE_MIN + sample_type'($urandom_range(0, 255));
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Mostly short windows keep the run fast; the clamp cases and the
   // largest spans show up now and then.
   function automatic window_type pick_window();
      case ($urandom_range(0, 19))
         0:       return window_type'(0);
         1:       return window_type'(MAX_WINDOW);
         2:       return window_type'($urandom_range(MAX_WINDOW + 1, 127));
         3:       return window_type'(127);
         4:       return window_type'(MAX_WINDOW - 1);
         5:       return window_type'($urandom_range(20, MAX_WINDOW - 2));
         default: return window_type'($urandom_range(1, 12));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Receiver side: checks every accepted average, stalls on its own
   // pattern, and once, on a long-hold request, holds ready low to back up the block.
   // ---------------------------------------------------------------------
   initial begin : sink_side
      sink_mode_type mode;
      int            mode_left;
      int            hold;
      int            tick;
      mode      = SINK_OPEN;
      mode_left = 0;
      hold      = 0;
      tick      = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (!reset && rsp_ch.valid && rsp_ch.ready) sb.match_average(rsp_ch.average);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = sink_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               SINK_OPEN:  rsp_ch.ready <= 1'b1;
               SINK_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               SINK_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default:    rsp_ch.ready <= (tick % 5) < 2;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: nothing accepted on either channel for too long ends the run
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      window_type w;
      int         len;
      int         end_odds;
      int         phase;
      int         i;
      bit         close_series;
      logic       last;

      req_ch.valid      <= 1'b0;
      req_ch.sample     <= '0;
      req_ch.series_end <= 1'b0;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset window (9): full-scale steps, then zero and -1 closing the series
      repeat (5) send_sample(SAMPLE_MAX, 1'b0);
      repeat (4) send_sample(SAMPLE_MIN, 1'b0);
      send_sample(sample_type'(0), 1'b0);
      send_sample(sample_type'(-1), 1'b1);

      // window 2: halves land exactly on .5, positive and negative ties
      write_window(window_type'(2));
      send_sample(sample_type'(1), 1'b0);
      send_sample(sample_type'(2), 1'b0);
      send_sample(sample_type'(-1), 1'b0);
      send_sample(sample_type'(-2), 1'b1);

      // window 0 acts as 1: averages are the samples themselves
      write_window(window_type'(0));
      send_sample(sample_type'(5), 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);

      // top register value clamps to MAX_WINDOW; series ends inside warm-up
      write_window(window_type'(127));
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);

      // window 3, weights 1-2-1 over 4: ties at one half, both signs
      write_window(window_type'(3));
      send_sample(sample_type'(2), 1'b0);
      send_sample(sample_type'(0), 1'b0);
      send_sample(sample_type'(0), 1'b0);
      send_sample(sample_type'(-2), 1'b1);

      // --- random phases ---
      // A phase picks a window, then streams a series. Half the phases leave
      // the series open, so the next window applies mid-series. Some phases
      // are choppy with frequent series ends (short, broken series).
      phase = 0;
      while (sb.requests < ITEMS_TARGET) begin
         phase++;
         if (phase == 3) begin
            // back-pressure: receiver holds off while requests keep coming
            write_window(window_type'(3));
            burst_left    = 1000;
            long_hold_req = 1'b1;
            for (i = 0; i < 40; i++) send_sample(random_sample(), 1'b0);
            burst_left = 0;
         end
         w = pick_window();
         write_window(w);
         len = (sb.span() > 20) ? $urandom_range(sb.span() + 16, sb.span() + 90)
                                : $urandom_range(8, 60);
         end_odds     = ($urandom_range(0, 7) == 0) ? 4 : 40;
         close_series = $urandom_range(0, 1);
         for (i = 0; i < len; i++) begin
            last = (i == len - 1) ? close_series : ($urandom_range(1, end_odds) == 1);
            send_sample(random_sample(), last);
         end
      end

      // --- drain ---
      req_ch.valid <= 1'b0;
      while (sb.expected_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      sb.close_out();

      $display("Run covered %0d requests in %0d closed series over %0d window writes,",
               sb.requests, sb.series_done, windows_tried);
      $display("with %0d averages compared against the predicted values.", sb.averages);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/tma_pkg.sv
rtl/core/tma_req_if.sv
rtl/core/tma_rsp_if.sv
rtl/core/tma_ram.sv
rtl/core/triangular_moving_average.sv
bench/tb_top.sv
